// File: hw/rtl/ogs_pkg.sv
package ogs_pkg;

    localparam int GRID_WIDTH  = 256;
    localparam int GRID_HEIGHT = 256;
    localparam int LOCAL_SIZE  = 1024;
    localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
    localparam int IDX_W       = $clog2(CELLS);
    localparam int GX_W        = $clog2(GRID_WIDTH);
    localparam int GY_W        = $clog2(GRID_HEIGHT);

    localparam logic [15:0] GRES_RESET = 16'd128;

    // division unit: 35-bit dividend (magnitude), 17-bit divisor
    localparam int DVD_W = 35;
    localparam int DVS_W = 17;

    typedef enum logic [1:0] {
        ACT_POSE  = 2'd0,
        ACT_CELL  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_UNANCHOR = 3'd1,
        ST_OOB      = 3'd2,
        ST_STALE    = 3'd3,
        ST_READ     = 3'd4,
        ST_POSE     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OCC_UNKNOWN  = 2'd0,
        OCC_FREE     = 2'd1,
        OCC_OCCUPIED = 2'd2
    } t_occ;

    typedef enum logic [1:0] {
        OP_EMIT  = 2'd0,   // result fully known at front end
        OP_WRITE = 2'd1,   // stamp check and write
        OP_READ  = 2'd2    // read cell
    } t_op;

    // one queue entry from front end to back end
    typedef struct packed {
        t_op         op;
        t_status     status;
        logic [15:0] index;
        logic        meas_known;
        logic        meas_occupied;
        logic [31:0] stamp;
        logic        anchored;
    } t_cmd;

    function automatic logic [7:0] occ_value(input logic [1:0] code);
        logic [7:0] v;
        v = 8'hFF;
        case (code)
            OCC_FREE:     v = 8'd0;
            OCC_OCCUPIED: v = 8'd100;
            default:      v = 8'hFF;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/ogs_fdiv.sv
// pipelined signed floor division of a 35-bit dividend by a 17-bit positive divisor,
// one quotient bit per stage; carries a valid bit alongside
module ogs_fdiv
    import ogs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]        i_divisor,
    output logic                    o_valid,
    output logic signed [DVD_W:0]   o_quot
);

    localparam int NS = DVD_W;

    logic [NS:0]       r_v;
    logic [DVD_W-1:0]  r_q   [NS+1];
    logic [DVS_W:0]    r_rem [NS+1];
    logic [DVS_W-1:0]  r_d   [NS+1];
    logic              r_neg [NS+1];

    // stage 0: take magnitude
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_dividend[DVD_W-1];
            r_q[0]   <= i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);
            r_rem[0] <= '0;
            r_d[0]   <= i_divisor;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            logic [DVS_W+1:0] sh;
            logic [DVS_W+1:0] df;
            assign sh = {r_rem[g], r_q[g][DVD_W-1]};
            assign df = sh - {2'b00, r_d[g]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_neg[g+1] <= r_neg[g];
                    r_d[g+1]   <= r_d[g];
                    if (!df[DVS_W+1]) begin
                        r_rem[g+1] <= df[DVS_W:0];
                        r_q[g+1]   <= {r_q[g][DVD_W-2:0], 1'b1};
                    end else begin
                        r_rem[g+1] <= sh[DVS_W:0];
                        r_q[g+1]   <= {r_q[g][DVD_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // floor: negative with remainder gives -(q+1)
    logic [DVD_W:0] mag;
    assign mag = {1'b0, r_q[NS]} + {{DVD_W{1'b0}}, (r_neg[NS] && (r_rem[NS] != '0))};
    assign o_quot  = r_neg[NS] ? -$signed(mag) : $signed(mag);
    assign o_valid = r_v[NS];

endmodule

// File: hw/rtl/ogs_front.sv
// front end: anchoring, world coordinate and cell mapping, classification
module ogs_front
    import ogs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_gres,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_pose_x,
    input  logic [31:0] i_pose_y,
    input  logic [31:0] i_local_origin_x,
    input  logic [31:0] i_local_origin_y,
    input  logic [15:0] i_local_resolution,
    input  logic [9:0]  i_local_col,
    input  logic [9:0]  i_local_row,
    input  logic [7:0]  i_measured_occupancy,
    input  logic [31:0] i_message_stamp,
    input  logic [15:0] i_read_index,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_space
);

    localparam int NS = DVD_W;  // index of the last divider stage

    // the pipeline moves as a whole and freezes while the queue is full or the memory clear runs
    logic en;
    assign en = i_cmd_space;
    assign o_ready = en;

    logic acc;
    assign acc = i_valid && en && (t_action'(i_action) != ACT_NONE);

    logic [15:0] gres;
    assign gres = (i_gres == '0) ? 16'd1 : i_gres;

    // anchoring
    logic               r_set;
    logic signed [31:0] r_ox, r_oy;
    logic signed [33:0] half_w, half_h, ax, ay;
    assign half_w = 34'((GRID_WIDTH  * 32'(gres)) / 2);
    assign half_h = 34'((GRID_HEIGHT * 32'(gres)) / 2);
    assign ax = 34'($signed(i_pose_x)) - half_w;
    assign ay = 34'($signed(i_pose_y)) - half_h;

    function automatic logic [31:0] sat(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sh07FFFFFFF)       r = 32'h7FFFFFFF;
        else if (v < -34'sh080000000) r = 32'h80000000;
        else                          r = v[31:0];
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set <= 1'b0;
            r_ox  <= '0;
            r_oy  <= '0;
        end else if (acc && t_action'(i_action) == ACT_POSE && !r_set) begin
            r_set <= 1'b1;
            r_ox  <= sat(ax);
            r_oy  <= sat(ay);
        end
    end

    // stage A: register operands for the products
    logic               r_av;
    t_action            r_aact;
    logic               r_aset;
    logic signed [31:0] r_alox, r_aloy, r_aox, r_aoy;
    logic [15:0]        r_alres, r_ares, r_aridx;
    logic [10:0]        r_acol2, r_arow2;
    logic [7:0]         r_ameas;
    logic [31:0]        r_astamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_av <= 1'b0;
        else if (en)  r_av <= acc;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_aact   <= t_action'(i_action);
            // a cell item sees the origin as of its own acceptance
            r_aset   <= r_set || (t_action'(i_action) == ACT_POSE);
            r_alox   <= i_local_origin_x;
            r_aloy   <= i_local_origin_y;
            r_aox    <= r_ox;
            r_aoy    <= r_oy;
            r_alres  <= (i_local_resolution == '0) ? 16'd1 : i_local_resolution;
            r_ares   <= gres;
            r_acol2  <= {i_local_col, 1'b1};
            r_arow2  <= {i_local_row, 1'b1};
            r_ameas  <= i_measured_occupancy;
            r_astamp <= i_message_stamp;
            r_aridx  <= i_read_index;
        end
    end

    // stage B: products
    logic               r_bv;
    t_action            r_bact;
    logic               r_bset;
    logic [26:0]        r_bpx, r_bpy;
    logic signed [33:0] r_bbx, r_bby;
    logic [15:0]        r_bres, r_bridx;
    logic [7:0]         r_bmeas;
    logic [31:0]        r_bstamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bv <= 1'b0;
        else if (en)  r_bv <= r_av;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bact   <= r_aact;
            r_bset   <= r_aset;
            r_bpx    <= 27'(r_acol2) * 27'(r_alres);
            r_bpy    <= 27'(r_arow2) * 27'(r_alres);
            // 2*(lo - origin)
            r_bbx    <= (34'(r_alox) - 34'(r_aox)) <<< 1;
            r_bby    <= (34'(r_aloy) - 34'(r_aoy)) <<< 1;
            r_bres   <= r_ares;
            r_bmeas  <= r_ameas;
            r_bstamp <= r_astamp;
            r_bridx  <= r_aridx;
        end
    end

    logic signed [DVD_W-1:0] dx, dy;
    assign dx = DVD_W'(r_bbx) + DVD_W'(r_bpx);
    assign dy = DVD_W'(r_bby) + DVD_W'(r_bpy);

    logic                  qxv, qyv;
    logic signed [DVD_W:0] qx, qy;

    ogs_fdiv u_divx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_bv),
        .i_dividend(dx), .i_divisor({r_bres, 1'b0}), .o_valid(qxv), .o_quot(qx)
    );
    ogs_fdiv u_divy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_bv),
        .i_dividend(dy), .i_divisor({r_bres, 1'b0}), .o_valid(qyv), .o_quot(qy)
    );

    // side info delayed to match divider
    t_action     r_sact   [NS+1];
    logic        r_sset   [NS+1];
    logic [15:0] r_sridx  [NS+1];
    logic [7:0]  r_smeas  [NS+1];
    logic [31:0] r_sstamp [NS+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sact[0]   <= r_bact;
            r_sset[0]   <= r_bset;
            r_sridx[0]  <= r_bridx;
            r_smeas[0]  <= r_bmeas;
            r_sstamp[0] <= r_bstamp;
            for (int k = 0; k < NS; k++) begin
                r_sact[k+1]   <= r_sact[k];
                r_sset[k+1]   <= r_sset[k];
                r_sridx[k+1]  <= r_sridx[k];
                r_smeas[k+1]  <= r_smeas[k];
                r_sstamp[k+1] <= r_sstamp[k];
            end
        end
    end

    t_action     act;
    logic [7:0]  meas;
    logic        in_grid;
    assign act  = r_sact[NS];
    assign meas = r_smeas[NS];
    assign in_grid = !qx[DVD_W] && !qy[DVD_W]
                  && (qx < (DVD_W+1)'(GRID_WIDTH)) && (qy < (DVD_W+1)'(GRID_HEIGHT));

    always_comb begin
        o_cmd               = '0;
        o_cmd.op            = OP_EMIT;
        o_cmd.status        = ST_POSE;
        o_cmd.stamp         = r_sstamp[NS];
        o_cmd.anchored      = r_sset[NS];
        o_cmd.meas_known    = (meas != 8'hFF);
        o_cmd.meas_occupied = ($signed(meas) >= 8'sd50);
        case (act)
            ACT_POSE: o_cmd.status = ST_POSE;
            ACT_CELL: begin
                if (!r_sset[NS]) begin
                    o_cmd.status = ST_UNANCHOR;
                end else if (!in_grid) begin
                    o_cmd.status = ST_OOB;
                end else begin
                    o_cmd.op    = OP_WRITE;
                    o_cmd.index = 16'(qy[GY_W-1:0] * GRID_WIDTH + qx[GX_W-1:0]);
                end
            end
            ACT_READ: begin
                o_cmd.index = r_sridx[NS];
                if (32'(r_sridx[NS]) >= CELLS) o_cmd.status = ST_OOB;
                else o_cmd.op = OP_READ;
            end
            default: o_cmd.status = ST_POSE;
        endcase
    end

    assign o_cmd_valid = qxv && qyv && en;

endmodule

// File: hw/rtl/ogs_back.sv
// back end: queue, cell memory read-modify-write with forwarding, output register
module ogs_back
    import ogs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_space,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_global_index,
    output logic [7:0]  o_occupancy_out,
    output logic        o_anchored
);

    // the front pipeline freezes while the queue is full, so at most one push a cycle
    localparam int QD   = 16;
    localparam int QA   = $clog2(QD);

    // clear pass over the cell memory after reset
    logic [IDX_W:0] r_clr;
    logic           clearing;
    assign clearing = !r_clr[IDX_W];

    t_cmd         r_q [QD];
    logic [QA:0]  r_wp, r_rp;
    logic [QA:0]  cnt;
    assign cnt = r_wp - r_rp;
    assign o_cmd_space = !clearing && !cnt[QA];

    // pipeline: queue head -> mem read (P1) -> resolve (P2) -> output reg
    logic r_p1v, r_p2v, r_ov;
    t_cmd r_p1, r_p2;
    logic adv;
    assign adv = !r_ov || i_ready;     // output register free

    logic pop;
    assign pop = (cnt != '0) && adv && !clearing;

    always_ff @(posedge i_clk) begin
        if (i_cmd_valid) r_q[r_wp[QA-1:0]] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_clr <= '0;
        end else begin
            if (i_cmd_valid) r_wp <= r_wp + 1'b1;
            if (pop)         r_rp <= r_rp + 1'b1;
            if (clearing)    r_clr <= r_clr + 1'b1;
        end
    end

    // memories
    logic [1:0]  r_occ_mem   [CELLS];
    logic [31:0] r_stamp_mem [CELLS];
    logic [1:0]  r_rd_occ;
    logic [31:0] r_rd_stamp;
    logic        we;
    logic [IDX_W-1:0] wa;
    logic [1:0]  wocc;
    logic [31:0] wstamp;

    t_cmd head;
    assign head = r_q[r_rp[QA-1:0]];

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_occ_mem[wa]   <= wocc;
            r_stamp_mem[wa] <= wstamp;
        end
        if (pop) begin
            r_rd_occ   <= r_occ_mem[head.index[IDX_W-1:0]];
            r_rd_stamp <= r_stamp_mem[head.index[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
        end else if (adv) begin
            r_p1v <= pop;
            r_p2v <= r_p1v;
        end
    end

    // forwarding registers for the result written at P2
    logic [1:0]  r_f1_occ;
    logic [31:0] r_f1_stamp;
    logic        r_f1_hit;
    logic [1:0]  r_p2_occ;
    logic [31:0] r_p2_stamp;

    // P2 write decision
    logic [1:0]  cur_occ;
    logic [31:0] cur_stamp;
    logic        stale;
    logic [1:0]  new_occ;

    always_comb begin
        cur_occ   = r_p2_occ;
        cur_stamp = r_p2_stamp;
        stale     = (r_p2.op == OP_WRITE) && (r_p2.stamp < cur_stamp);
        new_occ   = cur_occ;
        if (r_p2.meas_known) new_occ = r_p2.meas_occupied ? OCC_OCCUPIED : OCC_FREE;
        we     = clearing || (adv && r_p2v && r_p2.op == OP_WRITE && !stale);
        wa     = clearing ? r_clr[IDX_W-1:0] : r_p2.index[IDX_W-1:0];
        wocc   = clearing ? OCC_UNKNOWN : new_occ;
        wstamp = clearing ? 32'd0 : r_p2.stamp;
    end

    // P1 value: memory data, overridden by a write at P2 (same cycle) or one that
    // landed in the cycle the head was read, so the memory read returned old data
    logic [1:0]  p1_occ;
    logic [31:0] p1_stamp;
    logic        hit2;
    assign hit2 = r_p2v && r_p2.op == OP_WRITE && !stale && (r_p2.index == r_p1.index);
    always_comb begin
        p1_occ   = r_f1_hit ? r_f1_occ   : r_rd_occ;
        p1_stamp = r_f1_hit ? r_f1_stamp : r_rd_stamp;
        if (hit2) begin
            p1_occ   = new_occ;
            p1_stamp = r_p2.stamp;
        end
    end

    // r_f1: write that happened the cycle the head was read (memory read old data)
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1 <= head;
            r_f1_hit <= we && !clearing && (wa == head.index[IDX_W-1:0]);
            r_f1_occ   <= wocc;
            r_f1_stamp <= wstamp;
            r_p2 <= r_p1;
            r_p2_occ   <= p1_occ;
            r_p2_stamp <= p1_stamp;
        end
    end

    // output register
    t_status     r_ost;
    logic [15:0] r_oidx;
    logic [7:0]  r_oocc;
    logic        r_oanc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_p2v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_oidx <= r_p2.index;
            r_oanc <= r_p2.anchored;
            case (r_p2.op)
                OP_WRITE: begin
                    r_ost  <= stale ? ST_STALE : ST_UPDATED;
                    r_oocc <= occ_value(stale ? cur_occ : new_occ);
                end
                OP_READ: begin
                    r_ost  <= ST_READ;
                    r_oocc <= occ_value(cur_occ);
                end
                default: begin
                    r_ost  <= r_p2.status;
                    r_oocc <= 8'hFF;
                end
            endcase
        end
    end

    assign o_valid         = r_ov;
    assign o_status        = r_ost;
    assign o_global_index  = r_oidx;
    assign o_occupancy_out = r_oocc;
    assign o_anchored      = r_oanc;

endmodule

// File: hw/rtl/occupancy_grid_stitcher_core.sv
// channel | signals                                  | dir
// in      | i_valid / o_ready, i_action .. i_read_index | in
// out     | o_valid / i_ready, o_status .. o_anchored | out
// cfg     | i_cfg_we, i_cfg_wdata (global_resolution) | in
//
// One beat per cycle sustained while the queue has space; an accepted input beat passes
// 2 product stages, a 36-stage pipelined floor divider, a queue write, a
// 2-stage cell RMW and the output register before o_valid rises.
// After reset the 65536-entry cell memories are cleared, one entry a cycle, and
// o_ready stays low until the clear pass ends. Input stalls only while the 16-entry queue
// is full, which needs a stalled output; the output register decouples i_ready.
module occupancy_grid_stitcher_core
    import ogs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_pose_x,
    input  logic [31:0] i_pose_y,
    input  logic [31:0] i_local_origin_x,
    input  logic [31:0] i_local_origin_y,
    input  logic [15:0] i_local_resolution,
    input  logic [9:0]  i_local_col,
    input  logic [9:0]  i_local_row,
    input  logic [7:0]  i_measured_occupancy,
    input  logic [31:0] i_message_stamp,
    input  logic [15:0] i_read_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_global_index,
    output logic [7:0]  o_occupancy_out,
    output logic        o_anchored
);

    logic [15:0] r_gres;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_gres <= GRES_RESET;
        else if (i_cfg_we) r_gres <= i_cfg_wdata;
    end

    logic cmd_valid, cmd_space;
    t_cmd cmd;

    ogs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_gres(r_gres),
        .i_valid(i_valid), .o_ready(o_ready), .i_action(i_action),
        .i_pose_x(i_pose_x), .i_pose_y(i_pose_y),
        .i_local_origin_x(i_local_origin_x), .i_local_origin_y(i_local_origin_y),
        .i_local_resolution(i_local_resolution),
        .i_local_col(i_local_col), .i_local_row(i_local_row),
        .i_measured_occupancy(i_measured_occupancy),
        .i_message_stamp(i_message_stamp), .i_read_index(i_read_index),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_space(cmd_space)
    );

    ogs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_space(cmd_space),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_global_index(o_global_index), .o_occupancy_out(o_occupancy_out),
        .o_anchored(o_anchored)
    );

endmodule

// File: verif/ogs_checker.sv
`timescale 1ns / 1ps

module ogs_checker
    import ogs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] pose_x,
    input  logic [31:0] pose_y,
    input  logic [31:0] local_origin_x,
    input  logic [31:0] local_origin_y,
    input  logic [15:0] local_resolution,
    input  logic [9:0]  local_col,
    input  logic [9:0]  local_row,
    input  logic [7:0]  measured_occupancy,
    input  logic [31:0] message_stamp,
    input  logic [15:0] read_index,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [15:0] global_index,
    input  logic [7:0]  occupancy_out,
    input  logic        anchored,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        t_status     st;
        logic [15:0] idx;
        logic [7:0]  occ;
        logic        anch;
    } t_grid_result;

    t_occ        cell_occ [CELLS];
    logic [31:0] cell_stamp [CELLS];
    longint      org_x, org_y;
    logic        anch_q;
    logic [15:0] gres;
    t_grid_result grid_results[$];

    function automatic longint floor_quot(longint d, longint m);
        longint q;
        q = d / m;
        if ((d % m) != 0 && d < 0) q -= 1;
        return q;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [7:0] occ_byte(t_occ c);
        if (c == OCC_FREE) return 8'd0;
        if (c == OCC_OCCUPIED) return 8'd100;
        return 8'hFF;
    endfunction

    task automatic fuse_beat();
        t_grid_result e;
        longint gr, lres, lox, loy, px, py, w2x, w2y, mx, my;
        int idx;
        logic [7:0] meas;
        bit has_result;
        gr = (gres == 0) ? 1 : gres;
        e.st = ST_POSE;
        e.idx = '0;
        e.occ = 8'hFF;
        has_result = 1'b1;
        case (t_action'(action))
            ACT_POSE: begin
                if (!anch_q) begin
                    px = $signed(pose_x);
                    py = $signed(pose_y);
                    org_x = clamp32(px - floor_quot(GRID_WIDTH * gr, 2));
                    org_y = clamp32(py - floor_quot(GRID_HEIGHT * gr, 2));
                    anch_q = 1'b1;
                end
                e.st = ST_POSE;
            end
            ACT_CELL: begin
                lres = (local_resolution == 0) ? 1 : local_resolution;
                lox = $signed(local_origin_x);
                loy = $signed(local_origin_y);
                if (!anch_q) begin
                    e.st = ST_UNANCHOR;
                end else if (local_col >= LOCAL_SIZE || local_row >= LOCAL_SIZE) begin
                    e.st = ST_OOB;
                end else begin
                    w2x = 2 * lox + (2 * longint'(local_col) + 1) * lres;
                    w2y = 2 * loy + (2 * longint'(local_row) + 1) * lres;
                    mx = floor_quot(w2x - 2 * org_x, 2 * gr);
                    my = floor_quot(w2y - 2 * org_y, 2 * gr);
                    if (mx < 0 || mx >= GRID_WIDTH || my < 0 || my >= GRID_HEIGHT) begin
                        e.st = ST_OOB;
                    end else begin
                        idx = int'(my * GRID_WIDTH + mx);
                        e.idx = idx[15:0];
                        if (message_stamp < cell_stamp[idx]) begin
                            e.st = ST_STALE;
                        end else begin
                            meas = measured_occupancy;
                            if (meas != 8'hFF)
                                cell_occ[idx] = ($signed(meas) >= 50) ? OCC_OCCUPIED
                                                                      : OCC_FREE;
                            cell_stamp[idx] = message_stamp;
                            e.st = ST_UPDATED;
                        end
                        e.occ = occ_byte(cell_occ[idx]);
                    end
                end
            end
            ACT_READ: begin
                idx = read_index;
                e.idx = read_index;
                if (idx >= CELLS) begin
                    e.st = ST_OOB;
                end else begin
                    e.st = ST_READ;
                    e.occ = occ_byte(cell_occ[idx]);
                end
            end
            default: has_result = 1'b0;
        endcase
        e.anch = anch_q;
        if (has_result) grid_results.push_back(e);
    endtask

    always @(posedge clk) begin : watch
        t_grid_result e;
        if (!rst_n) begin
            foreach (cell_occ[i]) begin
                cell_occ[i] = OCC_UNKNOWN;
                cell_stamp[i] = '0;
            end
            org_x = 0;
            org_y = 0;
            anch_q = 1'b0;
            gres = GRES_RESET;
            grid_results.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) gres = cfg_wdata;
            if (out_valid && out_ready) begin
                if (grid_results.size() == 0) begin
                    $display("%0t: result with none expected:", $time,
                             " st=%0d idx=%0d occ=%0d anch=%0d",
                             status, global_index, $signed(occupancy_out), anchored);
                    fail_count <= fail_count + 1;
                end else begin
                    e = grid_results.pop_front();
                    if (status !== e.st || global_index !== e.idx ||
                        occupancy_out !== e.occ || anchored !== e.anch) begin
                        $display("%0t: mismatch expected st=%0d idx=%0d occ=%0d anch=%0d,",
                                 $time, e.st, e.idx, $signed(e.occ), e.anch,
                                 " got st=%0d idx=%0d occ=%0d anch=%0d",
                                 status, global_index, $signed(occupancy_out), anchored);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready) fuse_beat();
        end
        pending <= grid_results.size();
    end

endmodule

// File: verif/tb_occupancy_grid_stitcher_core.sv
`timescale 1ns / 1ps

module tb_occupancy_grid_stitcher_core;
    import ogs_pkg::*;

    typedef struct {
        logic [1:0]  act;
        logic [31:0] px, py, lox, loy;
        logic [15:0] lres;
        logic [9:0]  col, row;
        logic [7:0]  meas;
        logic [31:0] stamp;
        logic [15:0] ridx;
    } t_map_beat;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  in_action = '0;
    logic [31:0] in_pose_x = '0, in_pose_y = '0, in_lox = '0, in_loy = '0;
    logic [15:0] in_lres = '0;
    logic [9:0]  in_col = '0, in_row = '0;
    logic [7:0]  in_meas = '0;
    logic [31:0] in_stamp = '0;
    logic [15:0] in_ridx = '0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [2:0]  out_status;
    logic [15:0] out_index;
    logic [7:0]  out_occ;
    logic        out_anch;
    int          fail_count, pending;

    bit          no_idle = 1'b0;
    int          out_stall = 0;
    int          quiet_cycles = 0;
    longint      org_x, org_y, gres_eff;
    logic [31:0] stamp_ctr = 32'd1000;
    logic [15:0] last_idx = '0;

    always #5 clk = ~clk;

    occupancy_grid_stitcher_core i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_ready(in_ready), .i_action(in_action),
        .i_pose_x(in_pose_x), .i_pose_y(in_pose_y),
        .i_local_origin_x(in_lox), .i_local_origin_y(in_loy),
        .i_local_resolution(in_lres), .i_local_col(in_col), .i_local_row(in_row),
        .i_measured_occupancy(in_meas), .i_message_stamp(in_stamp),
        .i_read_index(in_ridx), .o_valid(out_valid), .i_ready(out_ready),
        .o_status(out_status), .o_global_index(out_index),
        .o_occupancy_out(out_occ), .o_anchored(out_anch)
    );

    ogs_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .action(in_action),
        .pose_x(in_pose_x), .pose_y(in_pose_y),
        .local_origin_x(in_lox), .local_origin_y(in_loy),
        .local_resolution(in_lres), .local_col(in_col), .local_row(in_row),
        .measured_occupancy(in_meas), .message_stamp(in_stamp),
        .read_index(in_ridx), .out_valid(out_valid), .out_ready(out_ready),
        .status(out_status), .global_index(out_index), .occupancy_out(out_occ),
        .anchored(out_anch), .fail_count(fail_count), .pending(pending)
    );

    // result side back-pressure
    always @(posedge clk) begin
        if (out_ready && out_valid) begin
            if (!no_idle && $urandom_range(0, 1)) begin
                out_ready <= 1'b0;
                out_stall <= int'($urandom_range(1, 11));
            end
        end else if (!out_ready) begin
            if (out_stall <= 1) out_ready <= 1'b1;
            out_stall <= out_stall - 1;
        end
    end

    // the cell clear after reset alone keeps the input quiet for the whole clear pass
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == 400000) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_map_beat noise_beat();
        t_map_beat b;
        b.act = 2'($urandom_range(0, 2));
        b.px = $urandom();
        b.py = $urandom();
        b.lox = $urandom();
        b.loy = $urandom();
        b.lres = 16'($urandom());
        b.col = 10'($urandom());
        b.row = 10'($urandom());
        b.meas = 8'($urandom());
        b.stamp = $urandom();
        b.ridx = 16'($urandom());
        return b;
    endfunction

    // local cell whose centre lands near global cell (mx, my)
    function automatic t_map_beat aimed_cell(longint mx, longint my, logic [7:0] meas,
                                              logic [31:0] stamp);
        t_map_beat b;
        longint lres, w2;
        b = noise_beat();
        b.act = ACT_CELL;
        b.lres = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 300));
        lres = (b.lres == 0) ? 1 : b.lres;
        if ($urandom_range(0, 1)) begin
            b.col = 10'($urandom_range(0, 15));
            b.row = 10'($urandom_range(0, 15));
        end
        w2 = 2 * org_x + 2 * gres_eff * mx + $urandom_range(0, 2 * gres_eff - 1);
        b.lox = 32'((w2 - (2 * longint'(b.col) + 1) * lres) >>> 1);
        w2 = 2 * org_y + 2 * gres_eff * my + $urandom_range(0, 2 * gres_eff - 1);
        b.loy = 32'((w2 - (2 * longint'(b.row) + 1) * lres) >>> 1);
        b.meas = meas;
        b.stamp = stamp;
        if (mx >= 0 && mx < GRID_WIDTH && my >= 0 && my < GRID_HEIGHT)
            last_idx = 16'(my * GRID_WIDTH + mx);
        return b;
    endfunction

    task automatic send(t_map_beat b);
        in_valid <= 1'b1;
        in_action <= b.act;
        in_pose_x <= b.px;
        in_pose_y <= b.py;
        in_lox <= b.lox;
        in_loy <= b.loy;
        in_lres <= b.lres;
        in_col <= b.col;
        in_row <= b.row;
        in_meas <= b.meas;
        in_stamp <= b.stamp;
        in_ridx <= b.ridx;
        do @(posedge clk); while (!in_ready);
        if (!no_idle && $urandom_range(0, 1)) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_resolution(logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        gres_eff = (v == 0) ? 1 : v;
    endtask

    function automatic logic [7:0] rand_meas();
        case ($urandom_range(0, 5))
            0: return 8'hFF;
            1: return 8'd49;
            2: return 8'd50;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic random_phase(int n);
        t_map_beat b;
        int pick;
        logic [31:0] st;
        for (int i = 0; i < n; i++) begin
            pick = int'($urandom_range(0, 99));
            stamp_ctr = stamp_ctr + $urandom_range(0, 3);
            st = ($urandom_range(0, 9) == 0) ? stamp_ctr - $urandom_range(1, 20) : stamp_ctr;
            if (pick < 55) begin
                b = aimed_cell(longint'(int'($urandom_range(0, 259)) - 2),
                               longint'(int'($urandom_range(0, 259)) - 2),
                               rand_meas(), st);
            end else if (pick < 70) begin
                b = noise_beat();
                b.act = ACT_READ;
                b.ridx = last_idx;
            end else if (pick < 80) begin
                b = noise_beat();
                b.act = ACT_READ;
            end else if (pick < 88) begin
                b = noise_beat();
                b.act = ACT_CELL;
            end else if (pick < 94) begin
                b = noise_beat();
                b.act = ACT_POSE;
            end else begin
                b = noise_beat();
                b.act = ACT_NONE;
            end
            send(b);
        end
    endtask

    initial begin
        t_map_beat b;
        logic [15:0] res_list [5];
        gres_eff = GRES_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // before anchoring
        b = noise_beat(); b.act = ACT_CELL; send(b);
        b = noise_beat(); b.act = ACT_READ; b.ridx = 16'd0; send(b);
        b = noise_beat(); b.act = ACT_READ; b.ridx = 16'hFFFF; send(b);
        b = noise_beat(); b.act = ACT_NONE; send(b);
        // anchor at the reset resolution
        b = noise_beat(); b.act = ACT_POSE; b.px = 32'd1000; b.py = -32'sd777; send(b);
        org_x = 1000 - GRID_WIDTH * gres_eff / 2;
        org_y = -777 - GRID_HEIGHT * gres_eff / 2;
        // later pose, extreme values, ignored
        b = noise_beat(); b.act = ACT_POSE; b.px = 32'h8000_0000; b.py = 32'h7FFF_FFFF; send(b);

        b = aimed_cell(10, 20, 8'd50, 32'd100); send(b);
        b = noise_beat(); b.act = ACT_READ; b.ridx = last_idx; send(b);
        b = aimed_cell(10, 20, 8'hFF, 32'd100); send(b);   // unknown, equal stamp
        b = aimed_cell(10, 20, 8'd49, 32'd99); send(b);    // stale
        b = aimed_cell(10, 20, 8'h80, 32'd200); send(b);   // most negative: free
        b = aimed_cell(255, 255, 8'd127, 32'hFFFF_FFFF); send(b);
        b = aimed_cell(0, 0, 8'd0, 32'd0); b.lres = 16'd0; send(b);
        b = aimed_cell(-1, 5, 8'd60, 32'd300); send(b);
        b = aimed_cell(5, 256, 8'd60, 32'd300); send(b);
        b = noise_beat(); b.act = ACT_CELL; b.col = 10'h3FF; b.row = 10'h3FF;
        b.lres = 16'hFFFF; b.lox = 32'h7FFF_FFFF; b.loy = 32'h8000_0000; send(b);
        b = noise_beat(); b.act = ACT_READ; b.ridx = 16'd65535; send(b);

        random_phase(280);
        res_list = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(2, 4000)), 16'd128};
        foreach (res_list[p]) begin
            set_resolution(res_list[p]);
            no_idle = (p % 3 == 1);
            random_phase(280);
        end
        no_idle = 1'b0;

        drain();
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
